// File: rtl/postfix_stack_evaluator_top_defines.svh
// assertion macros for the postfix evaluator
`ifndef POSTFIX_STACK_EVALUATOR_TOP_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PSE_ASSERT_NOW(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("pse: same-cycle check failed");
`define PSE_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("pse: next-cycle check failed");
`else
`define PSE_ASSERT_NOW(lbl, clk, rst, pre, post)
`define PSE_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif

`endif

// File: rtl/pse_pkg.sv
`default_nettype none

package pse_pkg;

   typedef logic signed [31:0] q16_type;

   localparam logic [1:0] REQ_PUSH    = 2'd0;
   localparam logic [1:0] REQ_APPLY   = 2'd1;
   localparam logic [1:0] REQ_FINISH  = 2'd2;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_UNDERFLOW   = 3'd1;
   localparam logic [2:0] ST_OVERFLOW    = 3'd2;
   localparam logic [2:0] ST_DIVZERO     = 3'd3;
   localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   localparam q16_type Q16_MAX = 32'sh7FFF_FFFF;
   localparam q16_type Q16_MIN = 32'sh8000_0000;

   // dividend is |a| shifted up by the fraction width
   localparam int DIV_STEPS = 48;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

endpackage

`default_nettype wire

// File: rtl/pse_alu.sv
`default_nettype none

module pse_alu
   import pse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  alu_cmd_type cmd,
   input  q16_type     opa,
   input  q16_type     opb,
   output logic        done,
   output q16_type     result
);

   typedef enum logic [1:0] {
      A_IDLE,
      A_MUL,
      A_DIV,
      A_FIX
   } alu_state_type;

   alu_state_type      state_ff, state_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [47:0]        quo_ff, quo_in;
   logic [31:0]        rem_ff, rem_in;
   logic [31:0]        dvs_ff, dvs_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               neg_ff, neg_in;
   logic               done_ff, done_in;
   q16_type            result_ff, result_in;

   logic [32:0]        sum;
   logic signed [63:0] rounded;
   logic [32:0]        trial;
   logic [31:0]        abs_a, abs_b;

   assign abs_a   = opa[31] ? (~opa + 32'd1) : opa;
   assign abs_b   = opb[31] ? (~opb + 32'd1) : opb;
   assign sum     = (cmd.op == ALU_SUB) ? ({opa[31], opa} - {opb[31], opb})
                                        : ({opa[31], opa} + {opb[31], opb});
   // round half up, then floor
   assign rounded = (prod_ff + 64'sd32768) >>> 16;
   assign trial   = {rem_ff, quo_ff[47]} - {1'b0, dvs_ff};

   always_comb begin
      state_in  = state_ff;
      prod_in   = prod_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      case (state_ff)
         A_IDLE: begin
            if (cmd.start) begin
               case (cmd.op)
                  ALU_ADD, ALU_SUB: begin
                     done_in = 1'b1;
                     if (sum[32] != sum[31]) begin
                        result_in = sum[32] ? Q16_MIN : Q16_MAX;
                     end else begin
                        result_in = sum[31:0];
                     end
                  end
                  ALU_MUL: begin
                     prod_in  = 64'(opa) * 64'(opb);
                     state_in = A_MUL;
                  end
                  default: begin
                     quo_in   = {abs_a, 16'd0};
                     dvs_in   = abs_b;
                     rem_in   = 32'd0;
                     cnt_in   = 6'd0;
                     neg_in   = opa[31] ^ opb[31];
                     state_in = A_DIV;
                  end
               endcase
            end
         end
         A_MUL: begin
            done_in  = 1'b1;
            state_in = A_IDLE;
            if ((&rounded[63:31]) || !(|rounded[63:31])) begin
               result_in = rounded[31:0];
            end else begin
               result_in = rounded[63] ? Q16_MIN : Q16_MAX;
            end
         end
         A_DIV: begin
            if (!trial[32]) begin
               rem_in = trial[31:0];
            end else begin
               rem_in = {rem_ff[30:0], quo_ff[47]};
            end
            quo_in = {quo_ff[46:0], !trial[32]};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) begin
               state_in = A_FIX;
            end
         end
         A_FIX: begin
            done_in  = 1'b1;
            state_in = A_IDLE;
            if (!neg_ff && (quo_ff > 48'h0000_7FFF_FFFF)) begin
               result_in = Q16_MAX;
            end else if (neg_ff && (quo_ff > 48'h0000_8000_0000)) begin
               result_in = Q16_MIN;
            end else if (neg_ff) begin
               result_in = ~quo_ff[31:0] + 32'd1;
            end else begin
               result_in = quo_ff[31:0];
            end
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      prod_ff   <= prod_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      cnt_ff    <= cnt_in;
      neg_ff    <= neg_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

// File: rtl/postfix_stack_evaluator_top.sv
// channel    direction  handshake            payload
// request    in         req_valid/req_stall  req_type, req_token_value, req_operator_char
// response   out        rsp_valid/rsp_stall  rsp_status, rsp_top_value, rsp_depth,
//                                            rsp_result_valid
//
// one request at a time; req_stall is high from acceptance until its response is registered
// push, finish and rejected requests answer from the execute state; add, subtract, multiply and divide
// go through the shared unit, divide by its one-bit-per-cycle restoring loop, and then write back
// the top value is held in a register, the rest of the stack in a one-read one-write memory
// synchronous reset empties the stack; a stalled response holds the next result back
`default_nettype none

`include "postfix_stack_evaluator_top_defines.svh"

module postfix_stack_evaluator_top
   import pse_pkg::*;
#(
   parameter int STACK_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  q16_type     req_token_value,
   input  logic [7:0]  req_operator_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output q16_type     rsp_top_value,
   output logic [4:0]  rsp_depth,
   output logic        rsp_result_valid
);

   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_CALC,
      S_WB
   } top_state_type;

   top_state_type    state_ff, state_in;
   logic [1:0]       type_ff, type_in;
   q16_type          token_ff, token_in;
   logic [7:0]       char_ff, char_in;
   logic [CNT_W-1:0] count_ff, count_in;
   q16_type          top_ff, top_in;
   q16_type          res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   q16_type          rsp_top_ff, rsp_top_in;
   logic [4:0]       rsp_depth_ff, rsp_depth_in;
   logic             rsp_result_valid_ff, rsp_result_valid_in;

   logic [31:0]      mem [STACK_DEPTH];
   q16_type          rd_data_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   logic [IDX_W-1:0] rd_idx;
   logic [CNT_W-1:0] count_m1;
   logic [CNT_W-1:0] count_m2;

   alu_cmd_type      alu_cmd;
   alu_op_type       alu_op;
   logic             alu_done;
   q16_type          alu_result;

   logic             op_known;
   logic             go_alu;
   logic             slot_free;
   q16_type          cur_top;

   assign count_m1  = count_ff - CNT_W'(1);
   assign count_m2  = count_ff - CNT_W'(2);
   assign rd_idx    = count_m2[IDX_W-1:0];
   assign mem_wa    = count_m1[IDX_W-1:0];
   assign cur_top   = (count_ff == '0) ? 32'sd0 : top_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign op_known  = (char_ff == CHAR_PLUS) || (char_ff == CHAR_MINUS) ||
                      (char_ff == CHAR_STAR) || (char_ff == CHAR_SLASH);
   assign go_alu    = (type_ff == REQ_APPLY) && op_known && (count_ff >= CNT_W'(2)) &&
                      !((char_ff == CHAR_SLASH) && (top_ff == 32'sd0));

   always_comb begin
      case (char_ff)
         CHAR_PLUS:  alu_op = ALU_ADD;
         CHAR_MINUS: alu_op = ALU_SUB;
         CHAR_STAR:  alu_op = ALU_MUL;
         default:    alu_op = ALU_DIV;
      endcase
   end

   assign alu_cmd.start = (state_ff == S_EXEC) && go_alu;
   assign alu_cmd.op    = alu_op;

   pse_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .opa    (rd_data_ff),
      .opb    (top_ff),
      .done   (alu_done),
      .result (alu_result)
   );

   always_comb begin
      state_in            = state_ff;
      type_in             = type_ff;
      token_in            = token_ff;
      char_in             = char_ff;
      count_in            = count_ff;
      top_in              = top_ff;
      res_in              = res_ff;
      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      rsp_status_in       = rsp_status_ff;
      rsp_top_in          = rsp_top_ff;
      rsp_depth_in        = rsp_depth_ff;
      rsp_result_valid_in = rsp_result_valid_ff;
      mem_we              = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               type_in  = req_type;
               token_in = req_token_value;
               char_in  = req_operator_char;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (go_alu) begin
               state_in = S_CALC;
            end else if (slot_free) begin
               state_in            = S_IDLE;
               rsp_valid_in        = 1'b1;
               rsp_status_in       = ST_OK;
               rsp_top_in          = cur_top;
               rsp_depth_in        = 5'(count_ff);
               rsp_result_valid_in = 1'b0;
               case (type_ff)
                  REQ_PUSH: begin
                     if (count_ff >= CNT_W'(STACK_DEPTH)) begin
                        rsp_status_in = ST_OVERFLOW;
                     end else begin
                        // spill the old top below the new one
                        mem_we       = (count_ff != '0);
                        top_in       = token_ff;
                        count_in     = count_ff + CNT_W'(1);
                        rsp_top_in   = token_ff;
                        rsp_depth_in = 5'(count_ff + CNT_W'(1));
                     end
                  end
                  REQ_APPLY: begin
                     if (!op_known) begin
                        rsp_status_in = ST_UNSUPPORTED;
                     end else if (count_ff < CNT_W'(2)) begin
                        rsp_status_in = ST_UNDERFLOW;
                     end else begin
                        rsp_status_in = ST_DIVZERO;
                     end
                  end
                  REQ_FINISH: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ST_UNDERFLOW;
                     end else begin
                        count_in            = '0;
                        rsp_depth_in        = 5'd0;
                        rsp_result_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_status_in = ST_UNSUPPORTED;
                  end
               endcase
            end
         end
         S_CALC: begin
            if (alu_done) begin
               res_in   = alu_result;
               state_in = S_WB;
            end
         end
         S_WB: begin
            if (slot_free) begin
               state_in            = S_IDLE;
               top_in              = res_ff;
               count_in            = count_m1;
               rsp_valid_in        = 1'b1;
               rsp_status_in       = ST_OK;
               rsp_top_in          = res_ff;
               rsp_depth_in        = 5'(count_m1);
               rsp_result_valid_in = 1'b0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff             <= type_in;
      token_ff            <= token_in;
      char_ff             <= char_in;
      top_ff              <= top_in;
      res_ff              <= res_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_top_ff          <= rsp_top_in;
      rsp_depth_ff        <= rsp_depth_in;
      rsp_result_valid_ff <= rsp_result_valid_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= top_ff;
      end
      rd_data_ff <= mem[rd_idx];
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_top_value    = rsp_top_ff;
   assign rsp_depth        = rsp_depth_ff;
   assign rsp_result_valid = rsp_result_valid_ff;

   `PSE_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(STACK_DEPTH))
   `PSE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `PSE_ASSERT_NOW(a_alu_done_in_calc, clock, reset, alu_done, state_ff == S_CALC)
   `PSE_ASSERT_NOW(a_finish_empties, clock, reset, rsp_valid && rsp_result_valid, (rsp_depth == 5'd0) && (rsp_status == ST_OK))

endmodule

`default_nettype wire

// File: bench/postfix_stack_evaluator_top_tb.sv
`timescale 1ns / 100ps

module postfix_stack_evaluator_top_tb;
   import pse_pkg::*;

   localparam int DEPTH_LIMIT = 16;
   localparam int TOTAL_REQUESTS = 1750;
   localparam int CALM_FROM = 1550;
   localparam int DIRECTED_ROWS = 24;
   localparam int PRINT_CAP = 40;
   localparam logic [1:0] REQ_RESERVED = 2'd3;
   localparam logic [7:0] CHAR_NONE = 8'h00;
   localparam logic [7:0] CHAR_HIGH = 8'hFF;
   localparam q16_type Q16_ONE = 32'sh0001_0000;
   localparam q16_type Q16_HALF = 32'sh0000_8000;
   localparam q16_type Q16_ONE_HALF = 32'sh0001_8000;

   typedef struct {
      logic [1:0] kind;
      q16_type    value;
      logic [7:0] op;
   } token_type;

   typedef struct {
      logic [2:0] status;
      q16_type    top;
      logic [4:0] depth;
      logic       done;
   } reply_type;

   typedef struct {
      logic [1:0] kind;
      q16_type    value;
      logic [7:0] op;
      int         reps;
      bit         typed;
      logic [2:0] status;
      q16_type    top;
      logic [4:0] depth;
      logic       done;
   } script_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_type = REQ_PUSH;
   q16_type    req_token_value = '0;
   logic [7:0] req_operator_char = CHAR_NONE;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   q16_type    rsp_top_value;
   logic [4:0] rsp_depth;
   logic       rsp_result_valid;

   q16_type   stack_mirror [0:DEPTH_LIMIT-1];
   int        stack_fill = 0;
   reply_type awaited_replies [$];

   bit idle_on = 1'b1;
   int stall_left = 0;
   int n_mismatch = 0;
   int n_sent = 0;
   int n_replies = 0;
   int n_results = 0;
   int n_rejected = 0;

   script_row_type script [0:DIRECTED_ROWS-1] = '{
      '{REQ_FINISH,   '0,           CHAR_NONE,  1,  1'b1, ST_UNDERFLOW,   '0,      5'd0,  1'b0},
      '{REQ_APPLY,    '0,           CHAR_PLUS,  1,  1'b1, ST_UNDERFLOW,   '0,      5'd0,  1'b0},
      '{REQ_RESERVED, '0,           CHAR_NONE,  1,  1'b1, ST_UNSUPPORTED, '0,      5'd0,  1'b0},
      '{REQ_PUSH,     Q16_MAX,      CHAR_NONE,  1,  1'b1, ST_OK,          Q16_MAX, 5'd1,  1'b0},
      '{REQ_APPLY,    '0,           CHAR_NONE,  1,  1'b1, ST_UNSUPPORTED, Q16_MAX, 5'd1,  1'b0},
      '{REQ_APPLY,    '0,           CHAR_STAR,  1,  1'b1, ST_UNDERFLOW,   Q16_MAX, 5'd1,  1'b0},
      '{REQ_PUSH,     Q16_MAX,      CHAR_NONE,  1,  1'b1, ST_OK,          Q16_MAX, 5'd2,  1'b0},
      '{REQ_APPLY,    '0,           CHAR_PLUS,  1,  1'b1, ST_OK,          Q16_MAX, 5'd1,  1'b0},
      '{REQ_PUSH,     Q16_MIN,      CHAR_NONE,  1,  1'b1, ST_OK,          Q16_MIN, 5'd2,  1'b0},
      '{REQ_APPLY,    '0,           CHAR_MINUS, 1,  1'b1, ST_OK,          Q16_MAX, 5'd1,  1'b0},
      '{REQ_PUSH,     '0,           CHAR_NONE,  1,  1'b1, ST_OK,          '0,      5'd2,  1'b0},
      '{REQ_APPLY,    '0,           CHAR_SLASH, 1,  1'b1, ST_DIVZERO,     '0,      5'd2,  1'b0},
      '{REQ_APPLY,    '0,           CHAR_HIGH,  1,  1'b1, ST_UNSUPPORTED, '0,      5'd2,  1'b0},
      '{REQ_FINISH,   '0,           CHAR_NONE,  1,  1'b1, ST_OK,          '0,      5'd0,  1'b1},
      '{REQ_PUSH,     Q16_MIN,      CHAR_NONE,  2,  1'b0, ST_OK,          '0,      5'd0,  1'b0},
      '{REQ_APPLY,    '0,           CHAR_STAR,  1,  1'b1, ST_OK,          Q16_MAX, 5'd1,  1'b0},
      '{REQ_PUSH,     Q16_ONE_HALF, CHAR_NONE,  1,  1'b0, ST_OK,          '0,      5'd0,  1'b0},
      '{REQ_APPLY,    '0,           CHAR_SLASH, 1,  1'b0, ST_OK,          '0,      5'd0,  1'b0},
      '{REQ_PUSH,     Q16_HALF,     CHAR_NONE,  1,  1'b0, ST_OK,          '0,      5'd0,  1'b0},
      '{REQ_APPLY,    '0,           CHAR_STAR,  1,  1'b0, ST_OK,          '0,      5'd0,  1'b0},
      '{REQ_FINISH,   '0,           CHAR_NONE,  1,  1'b0, ST_OK,          '0,      5'd0,  1'b0},
      '{REQ_PUSH,     32'sd3,       CHAR_NONE,  16, 1'b0, ST_OK,          '0,      5'd0,  1'b0},
      '{REQ_PUSH,     32'sh5555_AAAA, CHAR_NONE, 1, 1'b1, ST_OVERFLOW,    32'sd3,  5'd16, 1'b0},
      '{REQ_APPLY,    '0,           CHAR_MINUS, 15, 1'b0, ST_OK,          '0,      5'd0,  1'b0}
   };

   postfix_stack_evaluator_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_token_value   (req_token_value),
      .req_operator_char (req_operator_char),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_top_value     (rsp_top_value),
      .rsp_depth         (rsp_depth),
      .rsp_result_valid  (rsp_result_valid)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic q16_type clamp_q16(input longint v);
      if (v > longint'(Q16_MAX)) return Q16_MAX;
      if (v < longint'(Q16_MIN)) return Q16_MIN;
      return q16_type'(v);
   endfunction

   function automatic q16_type stack_top();
      return (stack_fill == 0) ? q16_type'(0) : stack_mirror[stack_fill - 1];
   endfunction

   function automatic reply_type rpn_apply_token(input token_type tok);
      reply_type r;
      longint a;
      longint b;
      longint acc;
      r = '{ST_OK, '0, '0, 1'b0};
      acc = 0;
      case (tok.kind)
         REQ_PUSH: begin
            if (stack_fill >= DEPTH_LIMIT) begin
               r.status = ST_OVERFLOW;
            end else begin
               stack_mirror[stack_fill] = tok.value;
               stack_fill++;
            end
            r.top = stack_top();
         end
         REQ_APPLY: begin
            if (tok.op != CHAR_PLUS && tok.op != CHAR_MINUS &&
                tok.op != CHAR_STAR && tok.op != CHAR_SLASH) begin
               r.status = ST_UNSUPPORTED;
            end else if (stack_fill < 2) begin
               r.status = ST_UNDERFLOW;
            end else begin
               b = longint'(stack_mirror[stack_fill - 1]);
               a = longint'(stack_mirror[stack_fill - 2]);
               case (tok.op)
                  CHAR_PLUS:  acc = a + b;
                  CHAR_MINUS: acc = a - b;
                  CHAR_STAR:  acc = (a * b + 32768) >>> 16;
                  default: begin
                     if (b == 0) r.status = ST_DIVZERO;
                     else acc = (a * 65536) / b;
                  end
               endcase
               if (r.status == ST_OK) begin
                  stack_fill--;
                  stack_mirror[stack_fill - 1] = clamp_q16(acc);
               end
            end
            r.top = stack_top();
         end
         REQ_FINISH: begin
            if (stack_fill == 0) begin
               r.status = ST_UNDERFLOW;
            end else begin
               r.top = stack_top();
               stack_fill = 0;
               r.done = 1'b1;
            end
         end
         default: begin
            r.status = ST_UNSUPPORTED;
            r.top = stack_top();
         end
      endcase
      r.depth = stack_fill[4:0];
      return r;
   endfunction

   function automatic q16_type random_q16();
      case ($urandom_range(0, 11))
         0: return Q16_MAX;
         1: return Q16_MIN;
         2, 3: return '0;
         4: return $urandom;
         5: return Q16_ONE;
         default: return q16_type'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      endcase
   endfunction

   function automatic logic [7:0] random_operator();
      case ($urandom_range(0, 9))
         0, 1: return CHAR_PLUS;
         2, 3: return CHAR_MINUS;
         4, 5: return CHAR_STAR;
         6, 7, 8: return CHAR_SLASH;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic flag_mismatch(input string what, input longint got, input longint want);
      n_mismatch++;
      if (n_mismatch <= PRINT_CAP)
         $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
   endtask

   task automatic send_token(input token_type tok, input bit typed,
                             input reply_type typed_reply);
      reply_type r;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= tok.kind;
      req_token_value <= tok.value;
      req_operator_char <= tok.op;
      do @(posedge clock); while (req_stall);
      r = rpn_apply_token(tok);
      if (typed) r = typed_reply;
      awaited_replies.push_back(r);
      n_sent++;
      @(negedge clock);
   endtask

   task automatic send_expression();
      token_type tok;
      reply_type none;
      int to_push;
      int steps;
      none = '{ST_OK, '0, '0, 1'b0};
      to_push = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 18) : $urandom_range(1, 5);
      steps = 0;
      while ((to_push > 0 || stack_fill > 1) && steps < 64) begin
         if (to_push > 0 && (stack_fill < 2 || $urandom_range(0, 1) == 1)) begin
            tok = '{REQ_PUSH, random_q16(), 8'($urandom)};
            to_push--;
         end else begin
            tok = '{REQ_APPLY, $urandom, random_operator()};
         end
         send_token(tok, 1'b0, none);
         steps++;
      end
      if ($urandom_range(0, 7) != 0) begin
         tok = '{REQ_FINISH, $urandom, 8'($urandom)};
         send_token(tok, 1'b0, none);
      end
   endtask

   // response back-pressure in short bursts
   always @(negedge clock) begin
      if (!idle_on) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_replies
      reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_replies++;
         if (awaited_replies.size() == 0) begin
            flag_mismatch("reply with nothing outstanding, status", rsp_status, 0);
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_status !== want.status)
               flag_mismatch("status", rsp_status, want.status);
            if (rsp_top_value !== want.top)
               flag_mismatch("top value", rsp_top_value, want.top);
            if (rsp_depth !== want.depth)
               flag_mismatch("depth", rsp_depth, want.depth);
            if (rsp_result_valid !== want.done)
               flag_mismatch("result valid", rsp_result_valid, want.done);
            if (want.done) n_results++;
            if (want.status != ST_OK) n_rejected++;
         end
      end
   end

   initial begin
      token_type tok;
      reply_type fixed_reply;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[i]) begin
         tok = '{script[i].kind, script[i].value, script[i].op};
         fixed_reply = '{script[i].status, script[i].top, script[i].depth, script[i].done};
         repeat (script[i].reps) send_token(tok, script[i].typed, fixed_reply);
      end

      while (n_sent < TOTAL_REQUESTS) begin
         if (n_sent >= CALM_FROM) idle_on = 1'b0;
         else idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) != 0) begin
            send_expression();
         end else begin
            repeat ($urandom_range(1, 4)) begin
               tok = '{2'($urandom_range(0, 3)), $urandom,
                       ($urandom_range(0, 1) == 1) ? random_operator() : CHAR_NONE};
               send_token(tok, 1'b0, fixed_reply);
            end
         end
      end
      req_valid <= 1'b0;

      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("%0d requests sent and %0d replies checked", n_sent, n_replies);
      $display("%0d expressions completed, %0d requests rejected with an error status",
               n_results, n_rejected);
      if (n_mismatch == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #(10_000_000);
      $display("Mismatches found");
      $finish;
   end

endmodule
